FILE: rtl/rdma_request_packet_sequencer_top_macros.svh
`ifndef RDMA_REQUEST_PACKET_SEQUENCER_TOP_MACROS_SVH
`define RDMA_REQUEST_PACKET_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RRPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrps assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define RRPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrps assertion failed");

`endif

FILE: rtl/rrps_pkg.sv
package rrps_pkg;

	localparam int PSN_BITS = 24;
	typedef logic [PSN_BITS-1:0] psn_t;

	// work-request kinds
	localparam logic [2:0] FUNC_SEND       = 3'd0;
	localparam logic [2:0] FUNC_SEND_IMM   = 3'd1;
	localparam logic [2:0] FUNC_SEND_INV   = 3'd2;
	localparam logic [2:0] FUNC_WRITE      = 3'd3;
	localparam logic [2:0] FUNC_WRITE_IMM  = 3'd4;
	localparam logic [2:0] FUNC_READ       = 3'd5;
	localparam logic [2:0] FUNC_CMP_SWAP   = 3'd6;
	localparam logic [2:0] FUNC_FETCH_ADD  = 3'd7;

	// transports
	localparam logic [1:0] KIND_RC = 2'd0;
	localparam logic [1:0] KIND_UC = 2'd1;
	localparam logic [1:0] KIND_UD = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_QP_KIND   = 2'd0;
	localparam logic [1:0] CFG_LOG2_MTU  = 2'd1;
	localparam logic [1:0] CFG_MAX_ACK   = 2'd2;
	localparam logic [1:0] CFG_START_PSN = 2'd3;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [3:0] LOG2_MTU_MIN   = 4'd8;
	localparam logic [3:0] LOG2_MTU_MAX   = 4'd12;
	localparam logic [3:0] LOG2_MTU_RESET = 4'd12;
	localparam logic [7:0] MAX_ACK_RESET  = 8'd64;
	localparam logic [7:0] UNACKED_SAT    = 8'hFF;

	// bth opcodes, rc numbering; uc adds the uc base
	localparam logic [7:0] OP_SEND_FIRST      = 8'h00;
	localparam logic [7:0] OP_SEND_MIDDLE     = 8'h01;
	localparam logic [7:0] OP_SEND_LAST       = 8'h02;
	localparam logic [7:0] OP_SEND_LAST_IMM   = 8'h03;
	localparam logic [7:0] OP_SEND_ONLY       = 8'h04;
	localparam logic [7:0] OP_SEND_ONLY_IMM   = 8'h05;
	localparam logic [7:0] OP_WRITE_FIRST     = 8'h06;
	localparam logic [7:0] OP_WRITE_MIDDLE    = 8'h07;
	localparam logic [7:0] OP_WRITE_LAST      = 8'h08;
	localparam logic [7:0] OP_WRITE_LAST_IMM  = 8'h09;
	localparam logic [7:0] OP_WRITE_ONLY      = 8'h0A;
	localparam logic [7:0] OP_WRITE_ONLY_IMM  = 8'h0B;
	localparam logic [7:0] OP_READ_REQ        = 8'h0C;
	localparam logic [7:0] OP_CMP_SWAP        = 8'h13;
	localparam logic [7:0] OP_FETCH_ADD       = 8'h14;
	localparam logic [7:0] OP_SEND_LAST_INV   = 8'h16;
	localparam logic [7:0] OP_SEND_ONLY_INV   = 8'h17;
	localparam logic [7:0] OP_UC_BASE         = 8'h20;
	localparam logic [7:0] OP_UD_SEND_ONLY    = 8'h64;
	localparam logic [7:0] OP_UD_SEND_ONLY_IMM = 8'h65;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_KIND = 2'd1,
		STATUS_UD_DROP  = 2'd2
	} status_t;

	// classified request, front to back
	typedef struct packed {
		logic        bad_kind;
		logic        ud_drop;
		logic        is_read;
		logic        chain;
		logic [6:0]  chain_op;
		logic [7:0]  op_cont;
		logic [7:0]  op_new;
		logic        pkt_end;
		logic [12:0] payload_len;
		logic [1:0]  pad_count;
		logic [31:0] bytes_left;
		psn_t        num_m1;
	} item_t;

	typedef struct packed {
		logic [7:0]  bth_opcode;
		logic [12:0] payload_len;
		logic [1:0]  pad_count;
		psn_t        packet_psn;
		psn_t        msg_first_psn;
		psn_t        msg_last_psn;
		logic        ack_request;
		logic        message_start;
		logic        message_end;
		logic [31:0] bytes_left_after;
		status_t     status;
	} res_t;

endpackage

FILE: rtl/rrps_channels.sv
interface rrps_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] remaining_bytes;

	modport source(output valid, output func, output remaining_bytes, input ready);
	modport sink(input valid, input func, input remaining_bytes, output ready);
endinterface

interface rrps_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  bth_opcode;
	logic [12:0] payload_len;
	logic [1:0]  pad_count;
	logic [23:0] packet_psn;
	logic [23:0] msg_first_psn;
	logic [23:0] msg_last_psn;
	logic        ack_request;
	logic        message_start;
	logic        message_end;
	logic [31:0] bytes_left_after;
	logic [1:0]  status;

	modport source(output valid, output bth_opcode, output payload_len, output pad_count,
		output packet_psn, output msg_first_psn, output msg_last_psn, output ack_request,
		output message_start, output message_end, output bytes_left_after, output status,
		input ready);
	modport sink(input valid, input bth_opcode, input payload_len, input pad_count,
		input packet_psn, input msg_first_psn, input msg_last_psn, input ack_request,
		input message_start, input message_end, input bytes_left_after, input status,
		output ready);
endinterface

FILE: rtl/rrps_front.sv
module rrps_front (
	rrps_req_if.sink       request,
	input  logic [1:0]     qp_kind,
	input  logic [3:0]     log2_mtu,
	input  logic           q_ready,
	output logic           push,
	output rrps_pkg::item_t item
);

	logic [3:0]  l2;
	logic [12:0] mtu;
	logic [31:0] rem;
	logic [31:0] rem_m1;
	logic [31:0] shifted;
	logic        fits;
	logic        is_data;
	logic        is_atomic;
	logic [7:0]  base;
	logic [7:0]  wfirst;
	logic [12:0] payload;
	logic [2:0]  func;

	assign request.ready = q_ready;
	assign push = request.valid && q_ready;

	always_comb begin
		func = request.func;
		rem = request.remaining_bytes;
		if (log2_mtu < rrps_pkg::LOG2_MTU_MIN) begin
			l2 = rrps_pkg::LOG2_MTU_MIN;
		end else if (log2_mtu > rrps_pkg::LOG2_MTU_MAX) begin
			l2 = rrps_pkg::LOG2_MTU_MAX;
		end else begin
			l2 = log2_mtu;
		end
		mtu = 13'd1 << l2;
		fits = (rem[31:13] == 19'd0) && (rem[12:0] <= mtu);
		is_data = (func <= rrps_pkg::FUNC_WRITE_IMM);
		is_atomic = (func == rrps_pkg::FUNC_CMP_SWAP) || (func == rrps_pkg::FUNC_FETCH_ADD);
		rem_m1 = rem - 32'd1;
		shifted = rem_m1 >> l2;
		base = (qp_kind == rrps_pkg::KIND_UC) ? rrps_pkg::OP_UC_BASE : 8'h00;
		wfirst = base | rrps_pkg::OP_WRITE_FIRST;
		payload = is_data ? (fits ? rem[12:0] : mtu) : 13'd0;

		item = '0;
		item.pkt_end = 1'b1;
		item.is_read = (func == rrps_pkg::FUNC_READ);
		item.payload_len = payload;
		item.pad_count = 2'd0 - payload[1:0];
		item.bytes_left = rem - {19'd0, payload};
		item.num_m1 = (rem == 32'd0 || is_atomic) ? '0 : shifted[rrps_pkg::PSN_BITS-1:0];

		if (qp_kind == rrps_pkg::KIND_UD) begin
			if (func == rrps_pkg::FUNC_SEND) begin
				item.op_new = rrps_pkg::OP_UD_SEND_ONLY;
			end else if (func == rrps_pkg::FUNC_SEND_IMM) begin
				item.op_new = rrps_pkg::OP_UD_SEND_ONLY_IMM;
			end else begin
				item.bad_kind = 1'b1;
			end
			item.op_cont = item.op_new;
		end else if (qp_kind != rrps_pkg::KIND_RC && qp_kind != rrps_pkg::KIND_UC) begin
			item.bad_kind = 1'b1;
		end else if (func <= rrps_pkg::FUNC_SEND_INV) begin
			item.bad_kind = (func == rrps_pkg::FUNC_SEND_INV) && (qp_kind != rrps_pkg::KIND_RC);
			item.chain = 1'b1;
			item.chain_op = base[7:1];
			item.pkt_end = fits;
			if (!fits) begin
				item.op_cont = base | rrps_pkg::OP_SEND_MIDDLE;
				item.op_new = base | rrps_pkg::OP_SEND_FIRST;
			end else if (func == rrps_pkg::FUNC_SEND) begin
				item.op_cont = base | rrps_pkg::OP_SEND_LAST;
				item.op_new = base | rrps_pkg::OP_SEND_ONLY;
			end else if (func == rrps_pkg::FUNC_SEND_IMM) begin
				item.op_cont = base | rrps_pkg::OP_SEND_LAST_IMM;
				item.op_new = base | rrps_pkg::OP_SEND_ONLY_IMM;
			end else begin
				item.op_cont = rrps_pkg::OP_SEND_LAST_INV;
				item.op_new = rrps_pkg::OP_SEND_ONLY_INV;
			end
		end else if (func <= rrps_pkg::FUNC_WRITE_IMM) begin
			item.chain = 1'b1;
			item.chain_op = wfirst[7:1];
			item.pkt_end = fits;
			if (!fits) begin
				item.op_cont = base | rrps_pkg::OP_WRITE_MIDDLE;
				item.op_new = base | rrps_pkg::OP_WRITE_FIRST;
			end else if (func == rrps_pkg::FUNC_WRITE) begin
				item.op_cont = base | rrps_pkg::OP_WRITE_LAST;
				item.op_new = base | rrps_pkg::OP_WRITE_ONLY;
			end else begin
				item.op_cont = base | rrps_pkg::OP_WRITE_LAST_IMM;
				item.op_new = base | rrps_pkg::OP_WRITE_ONLY_IMM;
			end
		end else if (qp_kind != rrps_pkg::KIND_RC) begin
			item.bad_kind = 1'b1;
		end else begin
			if (func == rrps_pkg::FUNC_READ) begin
				item.op_new = rrps_pkg::OP_READ_REQ;
			end else if (func == rrps_pkg::FUNC_CMP_SWAP) begin
				item.op_new = rrps_pkg::OP_CMP_SWAP;
			end else begin
				item.op_new = rrps_pkg::OP_FETCH_ADD;
			end
			item.op_cont = item.op_new;
		end

		item.ud_drop = (qp_kind == rrps_pkg::KIND_UD) && !fits && !item.bad_kind;
	end

endmodule

FILE: rtl/rrps_queue.sv
`include "rdma_request_packet_sequencer_top_macros.svh"

module rrps_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rrps_pkg::item_t push_item,
	output logic            ready,
	input  logic            pop,
	output logic            head_valid,
	output rrps_pkg::item_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rrps_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`RRPS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`RRPS_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == CW'($past(count_q) + CW'(1)))

endmodule

FILE: rtl/rrps_back.sv
`include "rdma_request_packet_sequencer_top_macros.svh"

module rrps_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      max_ack,
	input  logic            psn_load,
	input  rrps_pkg::psn_t  psn_load_value,
	input  logic            head_valid,
	input  rrps_pkg::item_t head,
	output logic            pop,
	rrps_rsp_if.source      result
);

	logic [7:0]      prev_opcode_q;
	logic            prev_valid_q;
	rrps_pkg::psn_t  next_psn_q;
	rrps_pkg::psn_t  head_psn_q;
	rrps_pkg::psn_t  tail_psn_q;
	logic [7:0]      unacked_q;
	logic            out_valid_q;
	rrps_pkg::res_t  res_q;

	logic            cont;
	logic            start;
	logic            ack;
	logic [7:0]      op;
	rrps_pkg::psn_t  psn;
	rrps_pkg::psn_t  first_d;
	rrps_pkg::psn_t  last_d;
	rrps_pkg::psn_t  next_d;
	logic [7:0]      unacked_d;
	logic [7:0]      prev_opcode_d;
	logic            prev_valid_d;
	rrps_pkg::res_t  res_d;

	assign pop = head_valid && (!out_valid_q || result.ready);

	always_comb begin
		psn = next_psn_q;
		cont = head.chain && prev_valid_q && (prev_opcode_q[7:1] == head.chain_op);
		start = !cont;
		op = cont ? head.op_cont : head.op_new;
		ack = head.pkt_end || (unacked_q > max_ack);

		first_d = head_psn_q;
		last_d = tail_psn_q;
		next_d = next_psn_q;
		unacked_d = unacked_q;
		prev_opcode_d = prev_opcode_q;
		prev_valid_d = prev_valid_q;
		res_d = '0;

		if (head.bad_kind) begin
			res_d.status = rrps_pkg::STATUS_BAD_KIND;
		end else if (head.ud_drop) begin
			first_d = psn;
			last_d = psn;
			next_d = psn + rrps_pkg::PSN_BITS'(1);
			prev_opcode_d = rrps_pkg::OP_UD_SEND_ONLY;
			prev_valid_d = 1'b1;
			res_d.packet_psn = psn;
			res_d.msg_first_psn = psn;
			res_d.msg_last_psn = psn;
			res_d.status = rrps_pkg::STATUS_UD_DROP;
		end else begin
			if (start) begin
				first_d = psn;
				last_d = psn + head.num_m1;
			end
			if (head.is_read) begin
				next_d = first_d + head.num_m1 + rrps_pkg::PSN_BITS'(1);
			end else begin
				next_d = psn + rrps_pkg::PSN_BITS'(1);
			end
			if (ack) begin
				unacked_d = 8'd0;
			end else if (unacked_q != rrps_pkg::UNACKED_SAT) begin
				unacked_d = unacked_q + 8'd1;
			end
			prev_opcode_d = op;
			prev_valid_d = 1'b1;
			res_d.bth_opcode = op;
			res_d.payload_len = head.payload_len;
			res_d.pad_count = head.pad_count;
			res_d.packet_psn = psn;
			res_d.msg_first_psn = first_d;
			res_d.msg_last_psn = last_d;
			res_d.ack_request = ack;
			res_d.message_start = start;
			res_d.message_end = head.pkt_end;
			res_d.bytes_left_after = head.bytes_left;
			res_d.status = rrps_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_opcode_q <= 8'd0;
			prev_valid_q <= 1'b0;
			next_psn_q <= '0;
			head_psn_q <= '0;
			tail_psn_q <= '0;
			unacked_q <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				prev_opcode_q <= prev_opcode_d;
				prev_valid_q <= prev_valid_d;
				head_psn_q <= first_d;
				tail_psn_q <= last_d;
				unacked_q <= unacked_d;
			end
			if (psn_load) begin
				next_psn_q <= psn_load_value;
			end else if (pop) begin
				next_psn_q <= next_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.bth_opcode = res_q.bth_opcode;
	assign result.payload_len = res_q.payload_len;
	assign result.pad_count = res_q.pad_count;
	assign result.packet_psn = res_q.packet_psn;
	assign result.msg_first_psn = res_q.msg_first_psn;
	assign result.msg_last_psn = res_q.msg_last_psn;
	assign result.ack_request = res_q.ack_request;
	assign result.message_start = res_q.message_start;
	assign result.message_end = res_q.message_end;
	assign result.bytes_left_after = res_q.bytes_left_after;
	assign result.status = res_q.status;

	`RRPS_ASSERT_IMP(a_end_acks,
		out_valid_q && res_q.status == rrps_pkg::STATUS_OK && res_q.message_end,
		res_q.ack_request)
	`RRPS_ASSERT_IMP(a_start_first,
		out_valid_q && res_q.status == rrps_pkg::STATUS_OK && res_q.message_start,
		res_q.msg_first_psn == res_q.packet_psn)

endmodule

FILE: rtl/rdma_request_packet_sequencer_top.sv
// request packet sequencer for one rdma queue pair
// request channel: one packet slot per request, the work-request kind (func)
//   and the bytes of the message still to send
// result channel: bth opcode, payload length, pad, psn, message first/last
//   psn, ack request, start/end marks, bytes left and a status code
// config port: cfg_we with cfg_index selects qp_kind, log2_mtu,
//   max_packets_per_ack or start_psn; writing start_psn reloads the next psn
// a request accepted at a clock edge is written into the queue and then
//   popped into the output register, which drives its result; one request
//   per cycle is sustained while the result receiver stays ready; the front
//   classifies a request in its accept cycle, and the back resolves continuation
//   against the previous opcode and psn state; that psn/opcode loop sets the rate
// when the result receiver stalls the output register holds, the queue fills,
//   and request ready drops once the queue is full
// reset clears the sequencing state: no message in flight, next psn zero,
//   mtu 4096, ack forced after 65 unacknowledged packets, rc transport
module rdma_request_packet_sequencer_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	rrps_req_if.sink                              request,
	rrps_rsp_if.source                            result,
	input  logic                                  cfg_we,
	input  logic [rrps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [rrps_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	logic [1:0]       qp_kind_q;
	logic [3:0]       log2_mtu_q;
	logic [7:0]       max_ack_q;
	logic             psn_load;
	logic             push;
	logic             q_ready;
	logic             pop;
	logic             head_valid;
	rrps_pkg::item_t  push_item;
	rrps_pkg::item_t  head;

	assign psn_load = cfg_we && (cfg_index == rrps_pkg::CFG_START_PSN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qp_kind_q <= rrps_pkg::KIND_RC;
			log2_mtu_q <= rrps_pkg::LOG2_MTU_RESET;
			max_ack_q <= rrps_pkg::MAX_ACK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rrps_pkg::CFG_QP_KIND: begin
					qp_kind_q <= cfg_data[1:0];
				end
				rrps_pkg::CFG_LOG2_MTU: begin
					log2_mtu_q <= cfg_data[3:0];
				end
				rrps_pkg::CFG_MAX_ACK: begin
					max_ack_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	rrps_front u_front (
		.request  (request),
		.qp_kind  (qp_kind_q),
		.log2_mtu (log2_mtu_q),
		.q_ready  (q_ready),
		.push     (push),
		.item     (push_item)
	);

	rrps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.ready      (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	rrps_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_ack        (max_ack_q),
		.psn_load       (psn_load),
		.psn_load_value (cfg_data[rrps_pkg::PSN_BITS-1:0]),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.result         (result)
	);

endmodule
